### rtl/core/ptpd_pkg.sv
// Shared types and constants for the point transform and perspective divide block.
package ptpd_pkg;

   localparam int unsigned REG_COUNT = 8;
   localparam int unsigned LANES     = 3;
   localparam int unsigned MAG_W     = 64;

   // Matrix register reset values: identity (listed from register 7 down to 0).
   localparam logic [REG_COUNT-1:0][63:0] REG_RESET = '{
      64'h0001_0000_0000_0000, 64'h0,
      64'h0000_0000_0001_0000, 64'h0,
      64'h0,                   64'h0001_0000_0000_0000,
      64'h0,                   64'h0000_0000_0001_0000
   };

   // Control that travels beside each beat through the pipeline.
   typedef struct packed {
      logic             valid;
      logic             wzero;
      logic [LANES-1:0] neg;
      logic [LANES-1:0] ovf;
   } ctl_type;

   // Divider working state: partial remainders and the shared divisor.
   typedef struct packed {
      logic [LANES-1:0][MAG_W-1:0] rem;
      logic [MAG_W-1:0]            div;
   } div_type;

endpackage

### rtl/core/ptpd_mac.sv
// Matrix multiply front end: products, column sums, magnitudes and divider setup.
module ptpd_mac #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        adv,
   input  logic                                        in_valid,
   input  logic signed [31:0]                          px,
   input  logic signed [31:0]                          py,
   input  logic signed [31:0]                          pz,
   input  logic [ptpd_pkg::REG_COUNT-1:0][63:0]        mat,
   output ptpd_pkg::ctl_type                           ctl_o,
   output ptpd_pkg::div_type                           div_o,
   output logic [ptpd_pkg::LANES-1:0][32+FRAC_BITS-1:0] num_o
);

   localparam int unsigned QW = 32 + FRAC_BITS;
   localparam logic [63:0] WZ_DIV = 64'd1 << (2 * FRAC_BITS);

   logic [3:0] v_ff, v_in;

   logic signed [63:0] prod_ff [4][3];
   logic signed [65:0] trans_ff [4];
   logic signed [65:0] pair_ff [4][2];
   logic signed [65:0] sum_ff [4];
   logic [63:0]        mag_ff [4];
   logic [3:0]         neg_ff;

   ptpd_pkg::ctl_type                           ctl_ff, ctl_in;
   ptpd_pkg::div_type                           div_ff, div_in;
   logic [ptpd_pkg::LANES-1:0][QW-1:0]          num_ff, num_in;

   logic signed [31:0] pt [3];
   assign pt[0] = px;
   assign pt[1] = py;
   assign pt[2] = pz;

   // valid bits advance with the data
   assign v_in = {v_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // stages 1 to 4: products, pair sums, column sum, sign and magnitude
   for (genvar c = 0; c < 4; c++) begin : g_col
      logic signed [31:0] elem [4];
      for (genvar r = 0; r < 4; r++) begin : g_row
         assign elem[r] = mat[r*2 + c/2][(c%2)*32 +: 32];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int r = 0; r < 3; r++) begin
               prod_ff[c][r] <= pt[r] * elem[r];
            end
            trans_ff[c]   <= 66'(elem[3]) <<< FRAC_BITS;
            pair_ff[c][0] <= 66'(prod_ff[c][0]) + 66'(prod_ff[c][1]);
            pair_ff[c][1] <= 66'(prod_ff[c][2]) + trans_ff[c];
            sum_ff[c]     <= pair_ff[c][0] + pair_ff[c][1];
            neg_ff[c]     <= sum_ff[c][65];
            mag_ff[c]     <= sum_ff[c][65] ? 64'(-sum_ff[c]) : sum_ff[c][63:0];
         end
      end
   end

   // stage 5: divisor select, overflow test and initial remainders
   always_comb begin
      logic wz;
      wz = (mag_ff[3] == '0);
      ctl_in.valid = v_ff[3];
      ctl_in.wzero = wz;
      // zero w divides by 2^(2F), which drops the extra fraction bits
      div_in.div   = wz ? WZ_DIV : mag_ff[3];
      for (int l = 0; l < ptpd_pkg::LANES; l++) begin
         ctl_in.neg[l] = wz ? neg_ff[l] : (neg_ff[l] ^ neg_ff[3]);
         ctl_in.ovf[l] = {32'd0, mag_ff[l][63:32]} >= div_in.div;
         div_in.rem[l] = {32'd0, mag_ff[l][63:32]};
         num_in[l]     = {mag_ff[l][31:0], {FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff <= div_in;
         num_ff <= num_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign div_o = div_ff;
   assign num_o = num_ff;

endmodule

### rtl/core/ptpd_div_stage.sv
// One restoring divide step for all three lanes, registered.
module ptpd_div_stage #(
   parameter int unsigned QW = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  ptpd_pkg::ctl_type                    ctl_i,
   input  ptpd_pkg::div_type                    div_i,
   input  logic [ptpd_pkg::LANES-1:0][QW-1:0]   num_i,
   output ptpd_pkg::ctl_type                    ctl_o,
   output ptpd_pkg::div_type                    div_o,
   output logic [ptpd_pkg::LANES-1:0][QW-1:0]   num_o
);

   ptpd_pkg::ctl_type                    ctl_ff;
   ptpd_pkg::div_type                    div_ff, div_in;
   logic [ptpd_pkg::LANES-1:0][QW-1:0]   num_ff, num_in;

   // shift in the next dividend bit, subtract when it fits, shift out a quotient bit
   always_comb begin
      logic [64:0] sh;
      logic [65:0] diff;
      div_in.div = div_i.div;
      for (int l = 0; l < ptpd_pkg::LANES; l++) begin
         sh   = {div_i.rem[l], num_i[l][QW-1]};
         diff = {1'b0, sh} - {2'b00, div_i.div};
         div_in.rem[l] = diff[65] ? sh[63:0] : diff[63:0];
         num_in[l]     = {num_i[l][QW-2:0], ~diff[65]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff <= div_in;
         num_ff <= num_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign div_o = div_ff;
   assign num_o = num_ff;

endmodule

### rtl/core/point_transform_perspective_divide_top.sv
// Top level: matrix registers, transform pipeline, divider chain and output clamp.
//
// Multiplies a Q16.16 point (w = 1) by a 4x4 matrix and divides x, y, z by w.
// req_ channel: one point per beat, px/py/pz in req_tdata.
// rsp_ channel: one result beat per point, in order, qx/qy/qz in rsp_tdata and
//   the w-zero and clamp flags in rsp_tuser.
// csr_ channel: writes one 64-bit matrix register; index 8 and up is ignored.
//   Write only while no beat is in flight.
// Pipeline: five front-end stages, one stage per quotient bit of the long divide,
//   and one output register.
// Throughput: one point per cycle unless the output stalls; the three divides run
//   as parallel lanes of one bit-per-stage restoring divider.
// Reset: pipeline emptied, matrix set to identity.
// Stall: while rsp_tready is low with a beat held, every stage holds and
//   req_tready drops; nothing is lost or repeated.
module point_transform_perspective_divide_top #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // px [31:0], py [63:32], pz [95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // qx [31:0], qy [63:32], qz [95:64]
   output logic [1:0]  rsp_tuser,   // w_was_zero [0], saturated [1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int unsigned QW = 32 + FRAC_BITS;

   logic adv;
   logic [ptpd_pkg::REG_COUNT-1:0][63:0] mat_ff;

   ptpd_pkg::ctl_type                       ctl_s [QW+1];
   ptpd_pkg::div_type                       div_s [QW+1];
   logic [ptpd_pkg::LANES-1:0][QW-1:0]      num_s [QW+1];

   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [95:0] rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]  rsp_tuser_ff, rsp_tuser_in;

   // whole pipeline moves unless the output beat is held
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // matrix registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= ptpd_pkg::REG_RESET;
      end else if (csr_valid && csr_index < 4'(ptpd_pkg::REG_COUNT)) begin
         mat_ff[csr_index[2:0]] <= csr_data;
      end
   end

   ptpd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid),
      .px       (req_tdata[31:0]),
      .py       (req_tdata[63:32]),
      .pz       (req_tdata[95:64]),
      .mat      (mat_ff),
      .ctl_o    (ctl_s[0]),
      .div_o    (div_s[0]),
      .num_o    (num_s[0])
   );

   // divider chain, one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_div
      ptpd_div_stage #(.QW(QW)) u_stage (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .ctl_i (ctl_s[k]),
         .div_i (div_s[k]),
         .num_i (num_s[k]),
         .ctl_o (ctl_s[k+1]),
         .div_o (div_s[k+1]),
         .num_o (num_s[k+1])
      );
   end

   // sign, clamp and pack
   always_comb begin
      logic [QW-1:0] q;
      logic          clip;
      logic          any;
      any = 1'b0;
      for (int l = 0; l < ptpd_pkg::LANES; l++) begin
         q = num_s[QW][l];
         if (ctl_s[QW].neg[l]) begin
            clip = ctl_s[QW].ovf[l] || (q > QW'(64'h8000_0000));
            rsp_tdata_in[l*32 +: 32] = clip ? 32'h8000_0000 : (32'd0 - q[31:0]);
         end else begin
            clip = ctl_s[QW].ovf[l] || (q > QW'(64'h7FFF_FFFF));
            rsp_tdata_in[l*32 +: 32] = clip ? 32'h7FFF_FFFF : q[31:0];
         end
         any = any | clip;
      end
      rsp_tuser_in  = {any, ctl_s[QW].wzero};
      rsp_tvalid_in = ctl_s[QW].valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // a clamp flag means some component sits at a range limit
   a_sat_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         rsp_tdata[31:0] == 32'h7FFF_FFFF || rsp_tdata[31:0] == 32'h8000_0000 ||
         rsp_tdata[63:32] == 32'h7FFF_FFFF || rsp_tdata[63:32] == 32'h8000_0000 ||
         rsp_tdata[95:64] == 32'h7FFF_FFFF || rsp_tdata[95:64] == 32'h8000_0000)
      else $error("saturated flag without a clamped component");

   // a held pipeline keeps its first divider beat in place
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(ctl_s[1]) && $stable(num_s[1]))
      else $error("divider stage moved during a stall");

   // writes beyond the register list leave the matrix alone
   a_csr_range : assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index >= 4'(ptpd_pkg::REG_COUNT) |=> $stable(mat_ff))
      else $error("out of range register write changed the matrix");

endmodule
